FILE: sv/mlb_pkg.sv
// Package: shared widths, defaults and the egress mask function of the learning bridge.
`default_nettype none
package mlb_pkg;
	localparam int ADDR_W            = 48;
	localparam int PORT_W            = 2;
	localparam int OUT_W             = 4;
	localparam int ENTRY_W           = ADDR_W + PORT_W;
	localparam int PORT_COUNT        = 4;
	localparam int TABLE_DEPTH_DEF   = 64;

	function automatic logic [OUT_W-1:0] port_mask(input logic hit,
			input logic [PORT_W-1:0] stored_port, input logic [PORT_W-1:0] rx_port);
		logic [OUT_W-1:0] m;
		m = '0;
		for (int i = 0; i < OUT_W; i++) begin
			if (hit) begin
				m[i] = (i < PORT_COUNT) && (stored_port == PORT_W'(i));
			end else begin
				m[i] = (i < PORT_COUNT) && (rx_port != PORT_W'(i));
			end
		end
		return m;
	endfunction
endpackage
`default_nettype wire

FILE: sv/mlb_hdr_if.sv
// Interface: frame header channel (valid/ready).
`default_nettype none
interface mlb_hdr_if
	import mlb_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] dst_address;
	logic [ADDR_W-1:0] src_address;
	logic [PORT_W-1:0] in_port;

	modport source (output valid, dst_address, src_address, in_port, input ready);
	modport sink (input valid, dst_address, src_address, in_port, output ready);
endinterface
`default_nettype wire

FILE: sv/mlb_fwd_if.sv
// Interface: forwarding decision channel (valid/ready).
`default_nettype none
interface mlb_fwd_if
	import mlb_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] out_ports;
	logic             flooded;
	logic             dst_hit;
	logic             src_new;
	logic             learn_dropped;

	modport source (output valid, out_ports, flooded, dst_hit, src_new, learn_dropped,
		input ready);
	modport sink (input valid, out_ports, flooded, dst_hit, src_new, learn_dropped,
		output ready);
endinterface
`default_nettype wire

FILE: sv/mlb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mlb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule
`default_nettype wire

FILE: sv/mac_learning_bridge_top.sv
// A header is taken in IDLE, then the table is scanned (SCAN), the source is learned (WRITE) and the
// result is loaded into the output register once it is free (DONE); no new header is taken until IDLE.
// The scan reads the table RAM one entry per cycle on its single read port.
// A new header is taken while the previous result still waits in the output register.
// Reset (arst_n low) empties the table by clearing the fill count; no clearing pass is needed.
// Entries are appended in order, so an entry is valid exactly when its index is below fill_count.
`default_nettype none
module mac_learning_bridge_top
	import mlb_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	mlb_hdr_if.sink  hdr,
	mlb_fwd_if.source fwd
);
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_WRITE = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  rd_idx_q;
	logic              rd_vld_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [ADDR_W-1:0] dst_q;
	logic [ADDR_W-1:0] src_q;
	logic [PORT_W-1:0] port_q;
	logic              dst_hit_q;
	logic [PORT_W-1:0] dst_port_q;
	logic              src_hit_q;
	logic [IDX_W-1:0]  src_slot_q;
	logic              new_q;
	logic              drop_q;

	logic              out_vld_q;
	logic [OUT_W-1:0]  out_ports_q;
	logic              out_flooded_q;
	logic              out_hit_q;
	logic              out_new_q;
	logic              out_drop_q;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_wa;
	logic              ram_re;
	logic [ENTRY_W-1:0] ram_rd;
	logic [ADDR_W-1:0] rd_addr_f;
	logic [PORT_W-1:0] rd_port_f;
	logic              out_free;
	logic              table_full;

	assign rd_addr_f  = ram_rd[ADDR_W-1:0];
	assign rd_port_f  = ram_rd[ENTRY_W-1:ADDR_W];
	assign out_free   = !out_vld_q || fwd.ready;
	assign table_full = (fill_q == CNT_W'(TABLE_DEPTH));
	assign hdr.ready  = (state_q == ST_IDLE);
	assign ram_re     = (state_q == ST_SCAN) && (rd_idx_q < fill_q);

	always_comb begin
		ram_we = 1'b0;
		ram_wa = src_slot_q;
		if (state_q == ST_WRITE) begin
			if (src_hit_q) begin
				ram_we = 1'b1;
			end else if (!table_full) begin
				ram_we = 1'b1;
				ram_wa = fill_q[IDX_W-1:0];
			end
		end
	end

	mlb_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_wa),
		.wr_data({port_q, src_q}),
		.rd_en  (ram_re),
		.rd_addr(rd_idx_q[IDX_W-1:0]),
		.rd_data(ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
			dst_hit_q <= 1'b0;
			src_hit_q <= 1'b0;
			new_q     <= 1'b0;
			drop_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_vld_q <= 1'b1;
			end else if (fwd.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (hdr.valid) begin
						rd_idx_q  <= '0;
						rd_vld_s1 <= 1'b0;
						dst_hit_q <= 1'b0;
						src_hit_q <= 1'b0;
						new_q     <= 1'b0;
						drop_q    <= 1'b0;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					rd_vld_s1 <= ram_re;
					if (ram_re) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (rd_vld_s1) begin
						if (!dst_hit_q && rd_addr_f == dst_q) begin
							dst_hit_q <= 1'b1;
						end
						if (!src_hit_q && rd_addr_f == src_q) begin
							src_hit_q <= 1'b1;
						end
					end
					if (!ram_re && !rd_vld_s1) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (!src_hit_q) begin
						if (table_full) begin
							drop_q <= 1'b1;
						end else begin
							new_q  <= 1'b1;
							fill_q <= fill_q + 1'b1;
						end
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && hdr.valid) begin
			dst_q  <= hdr.dst_address;
			src_q  <= hdr.src_address;
			port_q <= hdr.in_port;
		end
		if (state_q == ST_SCAN && rd_vld_s1) begin
			if (!dst_hit_q && rd_addr_f == dst_q) begin
				dst_port_q <= rd_port_f;
			end
			if (!src_hit_q && rd_addr_f == src_q) begin
				src_slot_q <= idx_s1;
			end
		end
		if (ram_re) begin
			idx_s1 <= rd_idx_q[IDX_W-1:0];
		end
		if (state_q == ST_DONE && out_free) begin
			out_ports_q   <= port_mask(dst_hit_q, dst_port_q, port_q);
			out_flooded_q <= !dst_hit_q;
			out_hit_q     <= dst_hit_q;
			out_new_q     <= new_q;
			out_drop_q    <= drop_q;
		end
	end

	assign fwd.valid         = out_vld_q;
	assign fwd.out_ports     = out_ports_q;
	assign fwd.flooded       = out_flooded_q;
	assign fwd.dst_hit       = out_hit_q;
	assign fwd.src_new       = out_new_q;
	assign fwd.learn_dropped = out_drop_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(TABLE_DEPTH))
		else $error("fill count beyond table depth");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != $past(fill_q)) |-> (fill_q == CNT_W'($past(fill_q) + 1'b1)))
		else $error("fill count moved by other than one");

	a_hit_xor_flood: assert property (@(posedge clk) disable iff (!arst_n)
		fwd.valid |-> (fwd.flooded ^ fwd.dst_hit))
		else $error("hit and flood flags disagree");

	a_new_drop: assert property (@(posedge clk) disable iff (!arst_n)
		fwd.valid |-> !(fwd.src_new && fwd.learn_dropped))
		else $error("source both learned and dropped");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !ram_re)
		else $error("table read during write-back");
endmodule
`default_nettype wire

FILE: bench/testbench.sv
// Testbench for mac_learning_bridge_top: directed and random frame headers checked against a local forwarding table.
`timescale 1ns / 1ps
module testbench;
	import mlb_pkg::*;

	localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
	localparam int POOL_SIZE   = 96;
	localparam int QUIET_LIMIT = 2000;
	localparam int PRINT_LIMIT = 50;

	localparam logic [ADDR_W-1:0] MAC_ZERO  = '0;
	localparam logic [ADDR_W-1:0] MAC_ONES  = '1;
	localparam logic [ADDR_W-1:0] MAC_A     = 48'h0200_5E10_0A01;
	localparam logic [ADDR_W-1:0] MAC_B     = 48'hA5A5_5A5A_0F0F;
	localparam logic [ADDR_W-1:0] MAC_C     = 48'h5A5A_A5A5_F0F0;
	localparam logic [ADDR_W-1:0] MAC_D     = 48'h0011_2233_4455;
	localparam logic [ADDR_W-1:0] MAC_UNSEEN = 48'h8000_0000_0001;

	typedef struct packed {
		logic [OUT_W-1:0] out_ports;
		logic             flooded;
		logic             dst_hit;
		logic             src_new;
		logic             learn_dropped;
	} fwd_decision_t;

	logic clk = 1'b0;
	logic arst_n;

	mlb_hdr_if hdr();
	mlb_fwd_if fwd();

	mac_learning_bridge_top #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.hdr(hdr),
		.fwd(fwd)
	);

	// forwarding table as the bridge should hold it
	logic              learned_valid[TABLE_DEPTH];
	logic [ADDR_W-1:0] learned_address[TABLE_DEPTH];
	logic [PORT_W-1:0] learned_port[TABLE_DEPTH];
	int                table_fill;

	fwd_decision_t     expected_decisions[$];
	logic [ADDR_W-1:0] mac_pool[POOL_SIZE];
	bit                idle_on;
	int                error_count;
	int                quiet_cycles;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int find_entry(input logic [ADDR_W-1:0] mac);
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			if (learned_valid[k] && learned_address[k] == mac)
				return k;
		end
		return -1;
	endfunction

	function automatic void predict_forward(input logic [ADDR_W-1:0] dst,
			input logic [ADDR_W-1:0] src, input logic [PORT_W-1:0] rx_port);
		fwd_decision_t d;
		int slot;
		d = '0;
		slot = find_entry(dst);
		if (slot >= 0) begin
			d.dst_hit = 1'b1;
			if (int'(learned_port[slot]) < PORT_COUNT)
				d.out_ports = OUT_W'(1) << learned_port[slot];
		end else begin
			d.flooded = 1'b1;
			d.out_ports = OUT_W'((1 << PORT_COUNT) - 1);
			if (int'(rx_port) < PORT_COUNT)
				d.out_ports &= ~(OUT_W'(1) << rx_port);
		end
		slot = find_entry(src);
		if (slot >= 0) begin
			learned_port[slot] = rx_port;
		end else if (table_fill < TABLE_DEPTH) begin
			learned_valid[table_fill] = 1'b1;
			learned_address[table_fill] = src;
			learned_port[table_fill] = rx_port;
			table_fill++;
			d.src_new = 1'b1;
		end else begin
			d.learn_dropped = 1'b1;
		end
		expected_decisions.push_back(d);
	endfunction

	function automatic logic [ADDR_W-1:0] random_mac();
		logic [ADDR_W-1:0] m;
		m[47:32] = 16'($urandom);
		m[31:0] = $urandom;
		return m;
	endfunction

	task automatic report_mismatch(input string msg);
		if (error_count < PRINT_LIMIT)
			$display("%0t ERROR %s", $realtime, msg);
		error_count++;
	endtask

	task automatic send_header(input logic [ADDR_W-1:0] dst, input logic [ADDR_W-1:0] src,
			input logic [PORT_W-1:0] rx_port);
		while (idle_on && $urandom_range(99) < 25) begin
			hdr.valid <= 1'b0;
			@(posedge clk);
		end
		hdr.valid <= 1'b1;
		hdr.dst_address <= dst;
		hdr.src_address <= src;
		hdr.in_port <= rx_port;
		do @(posedge clk); while (hdr.ready !== 1'b1);
		predict_forward(dst, src, rx_port);
	endtask

	task automatic send_random_header(input int pool_span, input int random_src_pct);
		logic [ADDR_W-1:0] dst;
		logic [ADDR_W-1:0] src;
		dst = ($urandom_range(99) < 75) ? mac_pool[$urandom_range(POOL_SIZE - 1)] : random_mac();
		src = ($urandom_range(99) < random_src_pct) ? random_mac()
			: mac_pool[$urandom_range(pool_span - 1)];
		send_header(dst, src, PORT_W'($urandom_range(3)));
	endtask

	// empty table floods; hits on learned ports; self-addressed new source misses
	task automatic test_flood_and_hit();
		send_header(MAC_ONES, MAC_ZERO, 2'd0);
		send_header(MAC_ZERO, MAC_ONES, 2'd3);
		send_header(MAC_ONES, MAC_A, 2'd1);
		send_header(MAC_B, MAC_B, 2'd2);
		send_header(MAC_B, MAC_C, 2'd2);
		send_header(MAC_A, MAC_D, 2'd0);
		send_header(MAC_UNSEEN, MAC_UNSEEN ^ MAC_ONES, 2'd1);
		send_header(MAC_UNSEEN, MAC_UNSEEN ^ MAC_ONES, 2'd3);
	endtask

	// known sources move to a new port, later lookups follow
	task automatic test_port_update();
		send_header(MAC_UNSEEN, MAC_ZERO, 2'd2);
		send_header(MAC_ZERO, MAC_A, 2'd3);
		send_header(MAC_A, MAC_ONES, 2'd1);
		send_header(MAC_ONES, MAC_B, 2'd0);
		send_header(MAC_B, MAC_B, 2'd0);
		send_header(MAC_ZERO, MAC_C, 2'd1);
		send_header(MAC_C, MAC_D, 2'd3);
		send_header(MAC_D, MAC_ZERO, 2'd0);
	endtask

	task automatic test_random_partial_table();
		for (int i = 0; i < 120; i++)
			send_random_header(POOL_SIZE / 2, 0);
	endtask

	task automatic test_random_fill_back_to_back();
		idle_on = 1'b0;
		for (int i = 0; i < 100; i++)
			send_random_header(POOL_SIZE, 10);
		idle_on = 1'b1;
	endtask

	task automatic test_random_full_table();
		for (int i = 0; i < 230; i++)
			send_random_header(POOL_SIZE, 10);
	endtask

	always @(posedge clk) begin
		fwd_decision_t e;
		if (fwd.valid === 1'b1 && fwd.ready === 1'b1) begin
			if (expected_decisions.size() == 0) begin
				report_mismatch("forwarding result with none expected");
			end else begin
				e = expected_decisions.pop_front();
				if (fwd.out_ports !== e.out_ports)
					report_mismatch($sformatf("out_ports got %h exp %h", fwd.out_ports,
						e.out_ports));
				if (fwd.flooded !== e.flooded)
					report_mismatch($sformatf("flooded got %b exp %b", fwd.flooded, e.flooded));
				if (fwd.dst_hit !== e.dst_hit)
					report_mismatch($sformatf("dst_hit got %b exp %b", fwd.dst_hit, e.dst_hit));
				if (fwd.src_new !== e.src_new)
					report_mismatch($sformatf("src_new got %b exp %b", fwd.src_new, e.src_new));
				if (fwd.learn_dropped !== e.learn_dropped)
					report_mismatch($sformatf("learn_dropped got %b exp %b",
						fwd.learn_dropped, e.learn_dropped));
			end
		end
		fwd.ready <= !idle_on || ($urandom_range(99) >= 25);
	end

	always @(posedge clk) begin
		if (!arst_n || (hdr.valid === 1'b1 && hdr.ready === 1'b1)
				|| (fwd.valid === 1'b1 && fwd.ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		hdr.valid = 1'b0;
		hdr.dst_address = '0;
		hdr.src_address = '0;
		hdr.in_port = '0;
		idle_on = 1'b1;
		table_fill = 0;
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			learned_valid[k] = 1'b0;
			learned_address[k] = '0;
			learned_port[k] = '0;
		end
		for (int k = 0; k < POOL_SIZE; k++)
			mac_pool[k] = random_mac();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_flood_and_hit();
		test_port_update();
		test_random_partial_table();
		test_random_fill_back_to_back();
		test_random_full_table();

		hdr.valid <= 1'b0;
		while (expected_decisions.size() != 0)
			@(posedge clk);
		repeat (TABLE_DEPTH + 10) @(posedge clk);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

FILE: files.f
sv/mlb_pkg.sv
sv/mlb_hdr_if.sv
sv/mlb_fwd_if.sv
sv/mlb_ram.sv
sv/mac_learning_bridge_top.sv
bench/testbench.sv
